// File: src/bee_pkg.sv
package bee_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int COORD_W        = 19;
    localparam int CNT_W          = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;

    localparam logic [2:0] CMD_WR_SRC  = 3'd0;
    localparam logic [2:0] CMD_WR_DST  = 3'd1;
    localparam logic [2:0] CMD_RD_DST  = 3'd2;
    localparam logic [2:0] CMD_FILL    = 3'd3;
    localparam logic [2:0] CMD_STRETCH = 3'd4;
    localparam logic [2:0] CMD_FAST    = 3'd5;

    localparam logic [2:0] CFG_DEST_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_DEST_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_SOURCE_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_SOURCE_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_KEY_COLOUR    = 3'd4;
    localparam logic [2:0] CFG_KEY_PRESENT   = 3'd5;

    typedef struct packed {
        logic [8:0] dest_width;
        logic [8:0] dest_height;
        logic [8:0] source_width;
        logic [8:0] source_height;
        logic [7:0] key_colour;
        logic       key_present;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] dest_left;
        logic signed [15:0] dest_top;
        logic signed [15:0] dest_right;
        logic signed [15:0] dest_bottom;
        logic signed [15:0] source_left;
        logic signed [15:0] source_top;
        logic signed [15:0] source_right;
        logic signed [15:0] source_bottom;
        logic               use_key;
        logic [15:0]        pixel_index;
        logic [7:0]         pixel_value;
    } item_t;

    typedef struct packed {
        logic [7:0]       read_value;
        logic [CNT_W-1:0] pixels_written;
    } res_t;

    function automatic logic signed [COORD_W-1:0] smax(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [COORD_W-1:0] smin(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// File: src/blit_engine_8bpp.sv
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata 152 bits, tuser 4 bits
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata 32 bits
// cfg       in   cfg_we                       cfg_index 3 bits, cfg_data 9 bits
// Pixel write and read items pass S_PXL, S_PXR and S_FIN; the store read is registered.
// Fill and blits step the clipped rectangle row by row and pixel by pixel; a stretch
// blit first runs the shared step divider for x, then for y.
// After reset both stores are cleared to zero, and no item is taken meanwhile.
// A result waiting on m_axis holds the next item only at its end.
module blit_engine_8bpp #(
    parameter int MAX_WIDTH  = bee_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bee_pkg::MAX_HEIGHT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // dest_left, dest_top, dest_right, dest_bottom, source_left, source_top,
    // source_right, source_bottom, pixel_index, pixel_value
    input  logic [151:0] s_axis_tdata,
    // command, use_key
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // read_value, pixels_written, zero pad
    output logic [31:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [8:0]   cfg_data
);

    bee_pkg::cfg_t  cfg_reg;
    bee_pkg::item_t item;
    bee_pkg::res_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_width    <= 9'd256;
            cfg_reg.dest_height   <= 9'd256;
            cfg_reg.source_width  <= 9'd256;
            cfg_reg.source_height <= 9'd256;
            cfg_reg.key_colour    <= 8'd0;
            cfg_reg.key_present   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bee_pkg::CFG_DEST_WIDTH:    cfg_reg.dest_width    <= cfg_data;
                bee_pkg::CFG_DEST_HEIGHT:   cfg_reg.dest_height   <= cfg_data;
                bee_pkg::CFG_SOURCE_WIDTH:  cfg_reg.source_width  <= cfg_data;
                bee_pkg::CFG_SOURCE_HEIGHT: cfg_reg.source_height <= cfg_data;
                bee_pkg::CFG_KEY_COLOUR:    cfg_reg.key_colour    <= cfg_data[7:0];
                bee_pkg::CFG_KEY_PRESENT:   cfg_reg.key_present   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        item.command       = s_axis_tuser[2:0];
        item.use_key       = s_axis_tuser[3];
        item.dest_left     = s_axis_tdata[15:0];
        item.dest_top      = s_axis_tdata[31:16];
        item.dest_right    = s_axis_tdata[47:32];
        item.dest_bottom   = s_axis_tdata[63:48];
        item.source_left   = s_axis_tdata[79:64];
        item.source_top    = s_axis_tdata[95:80];
        item.source_right  = s_axis_tdata[111:96];
        item.source_bottom = s_axis_tdata[127:112];
        item.pixel_index   = s_axis_tdata[143:128];
        item.pixel_value   = s_axis_tdata[151:144];
    end

    bee_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {7'd0, res.pixels_written, res.read_value};

endmodule

// File: src/bee_ram.sv
module bee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/bee_div.sv
module bee_div #(
    parameter int NW = 16,
    parameter int DW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   q_reg;
    logic [DW-1:0]   r_reg;
    logic [DW-1:0]   d_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            run_reg;
    logic            done_reg;
    logic [DW:0]     shifted;
    logic            fits;
    logic [DW:0]     diff;

    always_comb
    begin
        shifted = {r_reg, q_reg[NW-1]};
        fits    = shifted >= {1'b0, d_reg};
        diff    = shifted - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNTW'(NW);
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            run_reg  <= cnt_reg != CNTW'(1);
            done_reg <= cnt_reg == CNTW'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (run_reg)
        begin
            q_reg <= {q_reg[NW-2:0], fits};
            r_reg <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// File: src/bee_core.sv
module bee_core #(
    parameter int MAX_WIDTH  = bee_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bee_pkg::MAX_HEIGHT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  bee_pkg::cfg_t  cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  bee_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output bee_pkg::res_t  out_res
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = bee_pkg::COORD_W;
    localparam int QW    = 16;
    localparam int DVW   = (WW > HW) ? WW : HW;
    localparam int ARW   = WW + HW;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PXL   = 4'd2;
    localparam logic [3:0] S_PXR   = 4'd3;
    localparam logic [3:0] S_SETUP = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_DIVX  = 4'd6;
    localparam logic [3:0] S_DIVY  = 4'd7;
    localparam logic [3:0] S_ROW   = 4'd8;
    localparam logic [3:0] S_PIX   = 4'd9;
    localparam logic [3:0] S_DRAIN = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]             state_reg;
    logic [AW-1:0]          clr_reg;
    bee_pkg::item_t         f_reg;
    logic                   ok_reg;
    logic [7:0]             rd_reg;
    logic [bee_pkg::CNT_W-1:0] cnt_reg;
    logic                   go_reg;
    logic                   keyed_reg;
    logic [WW-1:0]          nx_reg;
    logic [HW-1:0]          ny_reg;
    logic [WW-1:0]          den_x_reg;
    logic [HW-1:0]          den_y_reg;
    logic signed [CW-1:0]   sbx_reg;
    logic signed [CW-1:0]   sby_reg;
    logic [WW-1:0]          dbx_reg;
    logic [HW-1:0]          dby_reg;
    logic [QW-1:0]          sw_reg;
    logic [QW-1:0]          sh_reg;
    logic [QW-1:0]          qxs_reg;
    logic [WW-1:0]          rxs_reg;
    logic [QW-1:0]          qys_reg;
    logic [HW-1:0]          rys_reg;
    logic signed [CW-1:0]   sx_reg;
    logic [WW-1:0]          rx_reg;
    logic signed [CW-1:0]   sy_reg;
    logic [HW-1:0]          ry_reg;
    logic [WW-1:0]          dx_reg;
    logic [WW-1:0]          xcnt_reg;
    logic [HW-1:0]          ycnt_reg;
    logic [AW-1:0]          dbase_reg;
    logic [AW-1:0]          srow_reg;
    logic                   row_ok_reg;
    logic                   p1_valid_reg;
    logic                   p1_fill_reg;
    logic [AW-1:0]          p1_addr_reg;
    logic                   out_valid_reg;
    bee_pkg::res_t          out_reg;

    logic [WW-1:0]        dw_e;
    logic [HW-1:0]        dh_e;
    logic [WW-1:0]        sw_e;
    logic [HW-1:0]        sh_e;
    logic signed [CW-1:0] dwc, dhc, swc, shc;
    logic signed [CW-1:0] dl, dt, dr, db, sl, st, sr, sb;
    logic signed [CW-1:0] x0, x1, y0, y1, swd, shd;
    logic signed [CW-1:0] fxlo, fxhi, fylo, fyhi;
    logic                 clip_ok;
    logic                 is_fill, is_str;
    logic [ARW-1:0]       area;
    logic                 idx_ok;
    logic                 div_start, div_done;
    logic [QW-1:0]        div_num, div_quot;
    logic [DVW-1:0]       div_den, div_rem;
    logic [WW:0]          rsum_x;
    logic                 wrap_x;
    logic [HW:0]          rsum_y;
    logic                 wrap_y;
    logic                 px_ok;
    logic                 p2_we;
    logic                 clr;
    logic                 src_we, dst_we;
    logic [AW-1:0]        src_waddr, dst_waddr, src_raddr, dst_raddr;
    logic [7:0]           src_wdata, dst_wdata, src_rdata, dst_rdata;

    always_comb
    begin
        if (cfg.dest_width == 9'd0)
            dw_e = WW'(1);
        else if (32'(cfg.dest_width) > 32'(MAX_WIDTH))
            dw_e = WW'(MAX_WIDTH);
        else
            dw_e = WW'(cfg.dest_width);
        if (cfg.source_width == 9'd0)
            sw_e = WW'(1);
        else if (32'(cfg.source_width) > 32'(MAX_WIDTH))
            sw_e = WW'(MAX_WIDTH);
        else
            sw_e = WW'(cfg.source_width);
        if (cfg.dest_height == 9'd0)
            dh_e = HW'(1);
        else if (32'(cfg.dest_height) > 32'(MAX_HEIGHT))
            dh_e = HW'(MAX_HEIGHT);
        else
            dh_e = HW'(cfg.dest_height);
        if (cfg.source_height == 9'd0)
            sh_e = HW'(1);
        else if (32'(cfg.source_height) > 32'(MAX_HEIGHT))
            sh_e = HW'(MAX_HEIGHT);
        else
            sh_e = HW'(cfg.source_height);
    end

    always_comb
    begin
        dwc = signed'(CW'(dw_e));
        dhc = signed'(CW'(dh_e));
        swc = signed'(CW'(sw_e));
        shc = signed'(CW'(sh_e));
        dl  = CW'(f_reg.dest_left);
        dt  = CW'(f_reg.dest_top);
        dr  = CW'(f_reg.dest_right);
        db  = CW'(f_reg.dest_bottom);
        sl  = CW'(f_reg.source_left);
        st  = CW'(f_reg.source_top);
        sr  = CW'(f_reg.source_right);
        sb  = CW'(f_reg.source_bottom);
        x0  = bee_pkg::smax(dl, '0);
        y0  = bee_pkg::smax(dt, '0);
        x1  = bee_pkg::smin(dr, dwc);
        y1  = bee_pkg::smin(db, dhc);
        clip_ok = (x0 < x1) && (y0 < y1);
        swd = sr - sl;
        shd = sb - st;
        fxlo = bee_pkg::smax(bee_pkg::smax(sl, '0), sl - dl);
        fxhi = bee_pkg::smin(bee_pkg::smin(sr, swc), sl - dl + dwc);
        fylo = bee_pkg::smax(bee_pkg::smax(st, '0), st - dt);
        fyhi = bee_pkg::smin(bee_pkg::smin(sb, shc), st - dt + dhc);
        is_fill = f_reg.command == bee_pkg::CMD_FILL;
        is_str  = f_reg.command == bee_pkg::CMD_STRETCH;
    end

    always_comb
    begin
        if (f_reg.command == bee_pkg::CMD_WR_SRC)
            area = ARW'(sw_e) * ARW'(sh_e);
        else
            area = ARW'(dw_e) * ARW'(dh_e);
        idx_ok = 32'(f_reg.pixel_index) < 32'(area);
    end

    always_comb
    begin
        rsum_x = (WW+1)'(rx_reg) + (WW+1)'(rxs_reg);
        wrap_x = rsum_x >= (WW+1)'(den_x_reg);
        rsum_y = (HW+1)'(ry_reg) + (HW+1)'(rys_reg);
        wrap_y = rsum_y >= (HW+1)'(den_y_reg);
        px_ok  = is_fill || (row_ok_reg && (sx_reg >= 0) && (sx_reg < swc));
        p2_we  = p1_valid_reg
              && (p1_fill_reg || !(keyed_reg && (src_rdata == cfg.key_colour)));
    end

    assign div_start = ((state_reg == S_MUL) && is_str)
                    || ((state_reg == S_DIVX) && div_done);
    assign div_num   = (state_reg == S_MUL) ? sw_reg : sh_reg;
    assign div_den   = (state_reg == S_MUL) ? DVW'(den_x_reg) : DVW'(den_y_reg);

    bee_div #(
        .NW (QW),
        .DW (DVW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    always_comb
    begin
        clr       = state_reg == S_CLR;
        src_we    = clr || ((state_reg == S_PXL) && idx_ok
                            && (f_reg.command == bee_pkg::CMD_WR_SRC));
        src_waddr = clr ? clr_reg : AW'(f_reg.pixel_index);
        src_wdata = clr ? 8'd0 : f_reg.pixel_value;
        src_raddr = srow_reg + AW'(sx_reg[WW-1:0]);
        dst_raddr = AW'(f_reg.pixel_index);
        if (clr)
        begin
            dst_we    = 1'b1;
            dst_waddr = clr_reg;
            dst_wdata = 8'd0;
        end
        else if (p2_we)
        begin
            dst_we    = 1'b1;
            dst_waddr = p1_addr_reg;
            dst_wdata = p1_fill_reg ? f_reg.pixel_value : src_rdata;
        end
        else
        begin
            dst_we    = (state_reg == S_PXL) && idx_ok
                     && (f_reg.command == bee_pkg::CMD_WR_DST);
            dst_waddr = AW'(f_reg.pixel_index);
            dst_wdata = f_reg.pixel_value;
        end
    end

    bee_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_src_ram (
        .clk   (clk),
        .we    (src_we),
        .waddr (src_waddr),
        .wdata (src_wdata),
        .raddr (src_raddr),
        .rdata (src_rdata)
    );

    bee_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_dst_ram (
        .clk   (clk),
        .we    (dst_we),
        .waddr (dst_waddr),
        .wdata (dst_wdata),
        .raddr (dst_raddr),
        .rdata (dst_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= (state_reg == S_PIX) && px_ok;
            if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        priority if (in_item.command == bee_pkg::CMD_WR_SRC
                                  || in_item.command == bee_pkg::CMD_WR_DST
                                  || in_item.command == bee_pkg::CMD_RD_DST)
                            state_reg <= S_PXL;
                        else if (in_item.command == bee_pkg::CMD_FILL
                              || in_item.command == bee_pkg::CMD_STRETCH
                              || in_item.command == bee_pkg::CMD_FAST)
                            state_reg <= S_SETUP;
                        else
                            state_reg <= S_FIN;
                    end
                end
                S_PXL:   state_reg <= S_PXR;
                S_PXR:   state_reg <= S_FIN;
                S_SETUP: state_reg <= S_MUL;
                S_MUL:
                begin
                    if (!go_reg)
                        state_reg <= S_FIN;
                    else if (is_str)
                        state_reg <= S_DIVX;
                    else
                        state_reg <= S_ROW;
                end
                S_DIVX:
                begin
                    if (div_done)
                        state_reg <= S_DIVY;
                end
                S_DIVY:
                begin
                    if (div_done)
                        state_reg <= S_ROW;
                end
                S_ROW:   state_reg <= S_PIX;
                S_PIX:
                begin
                    if (xcnt_reg == WW'(1))
                        state_reg <= (ycnt_reg == HW'(1)) ? S_DRAIN : S_ROW;
                end
                S_DRAIN: state_reg <= S_FIN;
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        p1_fill_reg <= is_fill;
        p1_addr_reg <= dbase_reg + AW'(dx_reg);
        if (p2_we && cnt_reg != bee_pkg::CNT_MAX)
            cnt_reg <= cnt_reg + 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                f_reg   <= in_item;
                rd_reg  <= 8'd0;
                cnt_reg <= '0;
            end
            S_PXL:
            begin
                ok_reg <= idx_ok;
                if (idx_ok && f_reg.command == bee_pkg::CMD_WR_DST)
                    cnt_reg <= bee_pkg::CNT_W'(1);
            end
            S_PXR:
            begin
                if (ok_reg && f_reg.command == bee_pkg::CMD_RD_DST)
                    rd_reg <= dst_rdata;
            end
            S_SETUP:
            begin
                keyed_reg <= f_reg.use_key && cfg.key_present;
                sw_reg    <= QW'(swd);
                sh_reg    <= QW'(shd);
                if (f_reg.command == bee_pkg::CMD_FAST)
                begin
                    go_reg    <= (fxlo < fxhi) && (fylo < fyhi);
                    nx_reg    <= WW'(fxhi - fxlo);
                    ny_reg    <= HW'(fyhi - fylo);
                    den_x_reg <= WW'(1);
                    den_y_reg <= HW'(1);
                    sbx_reg   <= fxlo;
                    sby_reg   <= fylo;
                    dbx_reg   <= WW'(dl + fxlo - sl);
                    dby_reg   <= HW'(dt + fylo - st);
                end
                else
                begin
                    go_reg    <= clip_ok && (is_fill || (swd > 0 && shd > 0));
                    nx_reg    <= WW'(x1 - x0);
                    ny_reg    <= HW'(y1 - y0);
                    den_x_reg <= WW'(x1 - x0);
                    den_y_reg <= HW'(y1 - y0);
                    sbx_reg   <= sl;
                    sby_reg   <= st;
                    dbx_reg   <= WW'(x0);
                    dby_reg   <= HW'(y0);
                end
            end
            S_MUL:
            begin
                dbase_reg <= AW'(dby_reg) * AW'(dw_e);
                sy_reg    <= sby_reg;
                ry_reg    <= '0;
                ycnt_reg  <= ny_reg;
                qxs_reg   <= QW'(1);
                rxs_reg   <= '0;
                qys_reg   <= QW'(1);
                rys_reg   <= '0;
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    qxs_reg <= div_quot;
                    rxs_reg <= WW'(div_rem);
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    qys_reg <= div_quot;
                    rys_reg <= HW'(div_rem);
                end
            end
            S_ROW:
            begin
                row_ok_reg <= (sy_reg >= 0) && (sy_reg < shc);
                srow_reg   <= AW'(sy_reg[HW-1:0]) * AW'(sw_e);
                sx_reg     <= sbx_reg;
                rx_reg     <= '0;
                dx_reg     <= dbx_reg;
                xcnt_reg   <= nx_reg;
            end
            S_PIX:
            begin
                xcnt_reg <= xcnt_reg - 1'b1;
                dx_reg   <= dx_reg + 1'b1;
                if (wrap_x)
                begin
                    rx_reg <= WW'(rsum_x - (WW+1)'(den_x_reg));
                    sx_reg <= sx_reg + signed'(CW'(qxs_reg)) + CW'(1);
                end
                else
                begin
                    rx_reg <= WW'(rsum_x);
                    sx_reg <= sx_reg + signed'(CW'(qxs_reg));
                end
                if (xcnt_reg == WW'(1))
                begin
                    ycnt_reg  <= ycnt_reg - 1'b1;
                    dbase_reg <= dbase_reg + AW'(dw_e);
                    if (wrap_y)
                    begin
                        ry_reg <= HW'(rsum_y - (HW+1)'(den_y_reg));
                        sy_reg <= sy_reg + signed'(CW'(qys_reg)) + CW'(1);
                    end
                    else
                    begin
                        ry_reg <= HW'(rsum_y);
                        sy_reg <= sy_reg + signed'(CW'(qys_reg));
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.read_value     <= rd_reg;
                    out_reg.pixels_written <= cnt_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

// File: src/bee_checker.sv
module bee_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[7:0] != 8'd0) |-> (m_axis_tdata[24:8] == 17'd0))
        else $error("read result with pixel count");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:25] == 7'd0))
        else $error("result pad not zero");

endmodule

bind blit_engine_8bpp bee_checker u_chk (.*);

// File: bench/blit_engine_8bpp_test.sv
`timescale 1ns / 1ps

module blit_engine_8bpp_test;
    import bee_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int STALL_LIMIT = 400000;
    localparam int LONG_HOLD = 400;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata = '0;
    logic [3:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [8:0]   cfg_data = '0;

    logic [7:0] src_pixels [STORE_DEPTH];
    logic [7:0] dst_pixels [STORE_DEPTH];
    cfg_t       surf_cfg;
    res_t       pending_results [$];
    int         fail_count = 0;
    int         quiet_cycles = 0;
    bit         gaps_on = 1'b1;
    bit         long_hold = 1'b0;

    blit_engine_8bpp i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_size(logic [8:0] r, int mx);
        longint v;
        v = r;
        if (v < 1) v = 1;
        if (v > mx) v = mx;
        return v;
    endfunction

    function automatic longint smax64(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint smin64(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic res_t blit_predict(item_t it);
        res_t   r;
        longint dl, dt, dr, db, sl, st, sr, sb;
        longint dw_s, dh_s, sw_s, sh_s;
        longint x0, y0, x1, y1, dw, dh, sw, sh, sx, sy, x, y, cnt;
        logic [7:0] p;
        bit     keyed;
        dl = it.dest_left;   dt = it.dest_top;
        dr = it.dest_right;  db = it.dest_bottom;
        sl = it.source_left; st = it.source_top;
        sr = it.source_right; sb = it.source_bottom;
        keyed = it.use_key && surf_cfg.key_present;
        dw_s = clamp_size(surf_cfg.dest_width, MAX_WIDTH_DEF);
        dh_s = clamp_size(surf_cfg.dest_height, MAX_HEIGHT_DEF);
        sw_s = clamp_size(surf_cfg.source_width, MAX_WIDTH_DEF);
        sh_s = clamp_size(surf_cfg.source_height, MAX_HEIGHT_DEF);
        r = '0;
        cnt = 0;
        case (it.command)
            CMD_WR_SRC: if (it.pixel_index < sw_s * sh_s) src_pixels[it.pixel_index] = it.pixel_value;
            CMD_WR_DST:
                if (it.pixel_index < dw_s * dh_s)
                begin
                    dst_pixels[it.pixel_index] = it.pixel_value;
                    cnt = 1;
                end
            CMD_RD_DST: if (it.pixel_index < dw_s * dh_s) r.read_value = dst_pixels[it.pixel_index];
            CMD_FILL, CMD_STRETCH:
            begin
                x0 = smax64(dl, 0);
                y0 = smax64(dt, 0);
                x1 = smin64(dr, dw_s);
                y1 = smin64(db, dh_s);
                if (x0 < x1 && y0 < y1)
                begin
                    dw = x1 - x0;
                    dh = y1 - y0;
                    sw = sr - sl;
                    sh = sb - st;
                    if (it.command == CMD_FILL)
                    begin
                        for (y = y0; y < y1; y++)
                            for (x = x0; x < x1; x++)
                            begin
                                dst_pixels[y * dw_s + x] = it.pixel_value;
                                cnt++;
                            end
                    end
                    else if (sw > 0 && sh > 0)
                    begin
                        for (y = 0; y < dh; y++)
                        begin
                            sy = st + (y * sh) / dh;
                            if (sy < 0 || sy >= sh_s) continue;
                            for (x = 0; x < dw; x++)
                            begin
                                sx = sl + (x * sw) / dw;
                                if (sx < 0 || sx >= sw_s) continue;
                                p = src_pixels[sy * sw_s + sx];
                                if (keyed && p == surf_cfg.key_colour) continue;
                                dst_pixels[(y0 + y) * dw_s + (x0 + x)] = p;
                                cnt++;
                            end
                        end
                    end
                end
            end
            CMD_FAST:
            begin
                y0 = smax64(smax64(st, 0), st - dt);
                y1 = smin64(smin64(sb, sh_s), st - dt + dh_s);
                x0 = smax64(smax64(sl, 0), sl - dl);
                x1 = smin64(smin64(sr, sw_s), sl - dl + dw_s);
                for (y = y0; y < y1; y++)
                    for (x = x0; x < x1; x++)
                    begin
                        p = src_pixels[y * sw_s + x];
                        if (keyed && p == surf_cfg.key_colour) continue;
                        dst_pixels[(dt + y - st) * dw_s + (dl + x - sl)] = p;
                        cnt++;
                    end
            end
            default: ;
        endcase
        if (cnt > CNT_MAX) cnt = CNT_MAX;
        r.pixels_written = cnt[CNT_W-1:0];
        return r;
    endfunction

    task automatic send_item(item_t it);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {it.use_key, it.command};
        s_axis_tdata  <= {it.pixel_value, it.pixel_index, it.source_bottom, it.source_right,
                          it.source_top, it.source_left, it.dest_bottom, it.dest_right,
                          it.dest_top, it.dest_left};
        do @(posedge clk); while (!s_axis_tready);
        pending_results.push_back(blit_predict(it));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [8:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_DEST_WIDTH:    surf_cfg.dest_width = val;
            CFG_DEST_HEIGHT:   surf_cfg.dest_height = val;
            CFG_SOURCE_WIDTH:  surf_cfg.source_width = val;
            CFG_SOURCE_HEIGHT: surf_cfg.source_height = val;
            CFG_KEY_COLOUR:    surf_cfg.key_colour = val[7:0];
            CFG_KEY_PRESENT:   surf_cfg.key_present = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic item_t make_item(logic [2:0] cmd, int dl, int dt, int dr, int db,
                                        int sl, int st, int sr, int sb, bit key,
                                        int idx, int val);
        item_t it;
        it.command = cmd;
        it.dest_left = dl;     it.dest_top = dt;
        it.dest_right = dr;    it.dest_bottom = db;
        it.source_left = sl;   it.source_top = st;
        it.source_right = sr;  it.source_bottom = sb;
        it.use_key = key;
        it.pixel_index = idx;
        it.pixel_value = val;
        return it;
    endfunction

    task automatic test_pixels_and_fill();
        send_item(make_item(CMD_RD_DST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535, 0));
        send_item(make_item(CMD_WR_SRC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255));
        send_item(make_item(CMD_WR_SRC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535, 8'ha5));
        send_item(make_item(CMD_WR_SRC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 257, 8'h3c));
        send_item(make_item(CMD_WR_DST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535, 8'h81));
        send_item(make_item(CMD_RD_DST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65535, 0));
        send_item(make_item(CMD_FILL, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0, 0, 8'h5a));
        send_item(make_item(CMD_RD_DST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1234, 0));
        send_item(make_item(CMD_FILL, 5, 5, 5, 9, 0, 0, 0, 0, 0, 0, 8'h11));
        send_item(make_item(3'd6, 1, 2, 3, 4, 5, 6, 7, 8, 1, 9, 10));
        send_item(make_item(3'd7, -1, -1, -1, -1, -1, -1, -1, -1, 1, 65535, 255));
        wait_drained();
    endtask

    task automatic test_blits();
        send_item(make_item(CMD_STRETCH, 10, 10, 14, 14, 0, 0, 2, 2, 0, 0, 0));
        send_item(make_item(CMD_STRETCH, -3, 250, 300, 300, 0, 0, 257, 2, 0, 0, 0));
        send_item(make_item(CMD_STRETCH, 0, 0, 4, 4, 3, 3, 3, 9, 0, 0, 0));
        send_item(make_item(CMD_FAST, -1, -1, 0, 0, 0, 0, 3, 3, 0, 0, 0));
        send_item(make_item(CMD_FAST, 254, 254, 0, 0, 0, 0, 4, 4, 0, 0, 0));
        send_item(make_item(CMD_FAST, 0, 0, 0, 0, -32768, -32768, 32767, 32767, 0, 0, 0));
        wait_drained();
        write_cfg(CFG_KEY_COLOUR, 9'h1ff);
        write_cfg(CFG_KEY_PRESENT, 9'h001);
        send_item(make_item(CMD_FAST, 2, 0, 0, 0, 0, 0, 8, 2, 1, 0, 0));
        send_item(make_item(CMD_STRETCH, 0, 2, 8, 4, 0, 0, 2, 2, 1, 0, 0));
        send_item(make_item(CMD_STRETCH, 0, 4, 8, 6, 0, 0, 2, 2, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_size_extremes();
        write_cfg(CFG_DEST_WIDTH, 9'd0);
        write_cfg(CFG_DEST_HEIGHT, 9'd511);
        write_cfg(CFG_SOURCE_WIDTH, 9'd511);
        write_cfg(CFG_SOURCE_HEIGHT, 9'd0);
        write_cfg(3'd6, 9'd3);
        write_cfg(3'd7, 9'd3);
        send_item(make_item(CMD_WR_DST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255, 8'h42));
        send_item(make_item(CMD_WR_DST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 256, 8'h43));
        send_item(make_item(CMD_RD_DST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 256, 0));
        send_item(make_item(CMD_WR_SRC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 300, 8'h77));
        send_item(make_item(CMD_FAST, 0, 0, 0, 0, 0, 0, 256, 256, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_backpressure();
        int n;
        long_hold = 1'b1;
        for (n = 0; n < 30; n++)
            send_item(make_item(n[0] ? CMD_RD_DST : CMD_WR_DST, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                $urandom_range(0, 300), $urandom_range(0, 255)));
        wait_drained();
    endtask

    function automatic int rand_coord(int span, bit wide);
        if (wide && $urandom_range(0, 9) == 0)
            return int'($signed(16'($urandom)));
        return $urandom_range(0, span + 6) - 3;
    endfunction

    function automatic logic [8:0] rand_size(bit small_only);
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'd1;
            2: return small_only ? 9'd16 : 9'($urandom_range(257, 511));
            3: return small_only ? 9'd2 : 9'd256;
            default: return 9'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic run_random_phase(int n_items, bit small_only);
        item_t  it;
        int     n, w, h, k;
        bit     wide;
        write_cfg(CFG_DEST_WIDTH, rand_size(small_only));
        write_cfg(CFG_DEST_HEIGHT, rand_size(small_only));
        write_cfg(CFG_SOURCE_WIDTH, rand_size(small_only));
        write_cfg(CFG_SOURCE_HEIGHT, rand_size(small_only));
        write_cfg(CFG_KEY_COLOUR, 9'($urandom_range(0, 511)));
        write_cfg(CFG_KEY_PRESENT, 9'($urandom_range(0, 511)));
        w = clamp_size(surf_cfg.dest_width, MAX_WIDTH_DEF);
        h = clamp_size(surf_cfg.dest_height, MAX_HEIGHT_DEF);
        wide = (w <= 16) && (h <= 16);
        if (w < 24) w = 24;
        for (n = 0; n < n_items; n++)
        begin
            it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            k = $urandom_range(0, 99);
            if (k < 35) it.command = CMD_WR_SRC;
            else if (k < 50) it.command = CMD_WR_DST;
            else if (k < 68) it.command = CMD_RD_DST;
            else if (k < 77) it.command = CMD_FILL;
            else if (k < 88) it.command = CMD_STRETCH;
            else if (k < 98) it.command = CMD_FAST;
            else it.command = 3'($urandom_range(6, 7));
            if ($urandom_range(0, 9) != 0)
                it.pixel_index = $urandom_range(0, w * h + 4);
            if (it.command >= CMD_FILL && it.command <= CMD_FAST)
            begin
                it.dest_left = rand_coord(20, wide);
                it.dest_top = rand_coord(20, wide);
                it.dest_right = it.dest_left + rand_coord(16, wide);
                it.dest_bottom = it.dest_top + rand_coord(16, wide);
                it.source_left = rand_coord(20, 1'b1);
                it.source_top = rand_coord(20, 1'b1);
                it.source_right = it.source_left + rand_coord(16, wide);
                it.source_bottom = it.source_top + rand_coord(16, wide);
                if (!wide && it.command == CMD_FAST)
                begin
                    it.source_left = rand_coord(20, 1'b0);
                    it.source_top = rand_coord(20, 1'b0);
                    it.source_right = it.source_left + rand_coord(16, 1'b0);
                    it.source_bottom = it.source_top + rand_coord(16, 1'b0);
                end
            end
            if (it.command == CMD_WR_SRC && surf_cfg.key_present && $urandom_range(0, 3) == 0)
                it.pixel_value = surf_cfg.key_colour;
            send_item(it);
        end
        wait_drained();
    endtask

    task automatic test_random();
        int p;
        for (p = 0; p < 10; p++)
            run_random_phase(160, p[0]);
        gaps_on = 1'b0;
        run_random_phase(150, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                if (m_axis_tdata[7:0] !== pending_results[0].read_value)
                begin
                    $display("%0t read_value mismatch: expected %h, actual %h", $time,
                             pending_results[0].read_value, m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tdata[24:8] !== pending_results[0].pixels_written)
                begin
                    $display("%0t pixels_written mismatch: expected %0d, actual %0d", $time,
                             pending_results[0].pixels_written, m_axis_tdata[24:8]);
                    fail_count++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[blit_engine_8bpp] ERROR");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                m_axis_tready <= 1'b0;
            else if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        foreach (src_pixels[i]) src_pixels[i] = '0;
        foreach (dst_pixels[i]) dst_pixels[i] = '0;
        surf_cfg = '{9'd256, 9'd256, 9'd256, 9'd256, 8'd0, 1'b0};
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_pixels_and_fill();
        test_blits();
        test_size_extremes();
        test_backpressure();
        test_random();
        repeat (50) @(negedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("[blit_engine_8bpp] OK");
        else
            $display("[blit_engine_8bpp] ERROR");
        $finish;
    end

endmodule
